// ===== rtl/core/hct_pkg.sv =====
// Shared types and constants of the handheld console timer.
// Used by hct_ctrl, hct_datapath and handheld_console_timer; depends on nothing.

package hct_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_ADVANCE = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;

    // Register addresses on the bus.
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;

    // Timer control fields.
    localparam int          TAC_START_BIT = 2;
    localparam logic [7:0]  TAC_READ_SET  = 8'hF8;

    // Rate codes in TAC bits 1..0.
    localparam logic [1:0] RATE_1024 = 2'd0;
    localparam logic [1:0] RATE_16   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;
    localparam logic [1:0] RATE_256  = 2'd3;

    // Timer prescaler and pending-increment widths.
    localparam int TPRE_W = 11;
    localparam int STEP_W = 7;

    typedef struct packed {
        logic accept;    // an item is taken this cycle
        logic step;      // run one iteration of the advance loops
        logic load_out;  // move the pending result into the output register
    } hct_cmd_t;

    typedef struct packed {
        logic div_busy;  // divider prescaler still holds a whole period
        logic tim_busy;  // TIMA increments still pending
    } hct_status_t;

endpackage

// ===== rtl/core/handheld_console_timer.sv =====
// Top level of the handheld console timer: controller plus datapath.
// Depends on hct_pkg, hct_ctrl and hct_datapath.

// The block models the DIV/TIMA timer of a handheld games console. Each item
// is a clock advance, a register read or a register write, and each gives
// exactly one result item. Items are handled one at a time: in_ready is high
// only while the controller is idle. A read, a write or an unused kind goes
// from idle straight to the done state, which moves its result into the output
// register once that register is free. An advance passes through the run
// state, where the divider prescaler subtracts one DIVIDER_PERIOD per cycle
// and TIMA handles one wrap or the last partial count per iteration (each
// wrap reloads from TMA, then counting carries on), both loops running side
// by side. With the default period the worst case is set by the TIMA loop
// with TMA at 0xFF and the RATE_16 setting. The next item is accepted while
// a finished result still waits in the output register for out_ready.

module handheld_console_timer
#(
    parameter int DIVIDER_PERIOD = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  cycle_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        overflow_irq
);

    hct_pkg::hct_cmd_t    cmd;
    hct_pkg::hct_status_t status;

    // The controller decides when an item is taken, when the advance loops
    // iterate and when a result moves into the output register.
    hct_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds all timer state and the output payload.
    hct_datapath #(
        .DIVIDER_PERIOD (DIVIDER_PERIOD)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .address      (address),
        .write_data   (write_data),
        .cycle_count  (cycle_count),
        .read_data    (read_data),
        .overflow_irq (overflow_irq)
    );

endmodule

// ===== rtl/core/hct_ctrl.sv =====
// Controller of the handheld console timer: sequences accept, iterate and deliver.
// Depends on hct_pkg.

module hct_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  hct_pkg::hct_status_t status,
    output hct_pkg::hct_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.accept   = in_valid && in_ready;
        cmd.step     = (state_reg == S_RUN);
        cmd.load_out = (state_reg == S_DONE) && out_free;

        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = (kind == hct_pkg::KIND_ADVANCE) ? S_RUN : S_DONE;
                end
            end
            S_RUN:
            begin
                if (!status.div_busy && !status.tim_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/hct_datapath.sv =====
// Datapath of the handheld console timer: DIV, TIMA, TMA, TAC, both prescalers,
// the iterative increment units and the result registers. Depends on hct_pkg.

module hct_datapath
#(
    parameter int DIVIDER_PERIOD = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hct_pkg::hct_cmd_t    cmd,
    output hct_pkg::hct_status_t status,
    input  logic [1:0]           kind,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    input  logic [7:0]           cycle_count,
    output logic [7:0]           read_data,
    output logic                 overflow_irq
);

    localparam int DIV_PRE_W = $clog2(DIVIDER_PERIOD + 256);
    localparam logic [DIV_PRE_W-1:0] DIV_PERIOD_V = DIV_PRE_W'(DIVIDER_PERIOD);

    logic [7:0]                   div_count_reg;
    logic [DIV_PRE_W-1:0]         div_pre_reg;
    logic [7:0]                   tima_reg;
    logic [7:0]                   tma_reg;
    logic [7:0]                   tac_reg;
    logic [hct_pkg::TPRE_W-1:0]   tpre_reg;
    logic [hct_pkg::STEP_W-1:0]   steps_reg;
    logic [7:0]                   res_data_reg;
    logic                         irq_acc_reg;
    logic [7:0]                   read_data_reg;
    logic                         overflow_irq_reg;

    logic [7:0]                   rd_value;
    logic [DIV_PRE_W-1:0]         div_sum;
    logic [hct_pkg::TPRE_W-1:0]   tsum;
    logic [hct_pkg::STEP_W-1:0]   steps_start;
    logic [hct_pkg::TPRE_W-1:0]   trem;
    logic [8:0]                   gap;
    logic                         chunk_wrap;

    assign read_data    = read_data_reg;
    assign overflow_irq = overflow_irq_reg;

    assign status.div_busy = (div_pre_reg >= DIV_PERIOD_V);
    assign status.tim_busy = (steps_reg != '0);

    always_comb
    begin
        case (address)
            hct_pkg::ADDR_DIV:  rd_value = div_count_reg;
            hct_pkg::ADDR_TIMA: rd_value = tima_reg;
            hct_pkg::ADDR_TMA:  rd_value = tma_reg;
            hct_pkg::ADDR_TAC:  rd_value = tac_reg | hct_pkg::TAC_READ_SET;
            default:            rd_value = 8'd0;
        endcase
    end

    assign div_sum = div_pre_reg + DIV_PRE_W'(cycle_count);
    assign tsum    = tpre_reg + hct_pkg::TPRE_W'(cycle_count);

    // Timer periods are powers of two, so the whole periods held are a shift
    // and what is left over is a mask.
    always_comb
    begin
        case (tac_reg[1:0])
            hct_pkg::RATE_16:
            begin
                steps_start = tsum[10:4];
                trem        = {7'd0, tsum[3:0]};
            end
            hct_pkg::RATE_64:
            begin
                steps_start = {2'd0, tsum[10:6]};
                trem        = {5'd0, tsum[5:0]};
            end
            hct_pkg::RATE_256:
            begin
                steps_start = {4'd0, tsum[10:8]};
                trem        = {3'd0, tsum[7:0]};
            end
            default:
            begin
                steps_start = {6'd0, tsum[10]};
                trem        = {1'b0, tsum[9:0]};
            end
        endcase
    end

    // Increments left before TIMA wraps; a chunk either reaches the wrap or
    // finishes the pending count.
    assign gap        = 9'd256 - {1'b0, tima_reg};
    assign chunk_wrap = ({2'd0, steps_reg} >= gap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_count_reg    <= '0;
            div_pre_reg      <= '0;
            tima_reg         <= '0;
            tma_reg          <= '0;
            tac_reg          <= '0;
            tpre_reg         <= '0;
            steps_reg        <= '0;
            res_data_reg     <= '0;
            irq_acc_reg      <= 1'b0;
            read_data_reg    <= '0;
            overflow_irq_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                irq_acc_reg  <= 1'b0;
                res_data_reg <= (kind == hct_pkg::KIND_READ) ? rd_value : 8'd0;
                case (kind)
                    hct_pkg::KIND_ADVANCE:
                    begin
                        div_pre_reg <= div_sum;
                        if (tac_reg[hct_pkg::TAC_START_BIT])
                        begin
                            tpre_reg  <= trem;
                            steps_reg <= steps_start;
                        end
                    end
                    hct_pkg::KIND_WRITE:
                    begin
                        case (address)
                            hct_pkg::ADDR_DIV:  div_count_reg <= 8'd0;
                            hct_pkg::ADDR_TIMA: tima_reg      <= write_data;
                            hct_pkg::ADDR_TMA:  tma_reg       <= write_data;
                            hct_pkg::ADDR_TAC:  tac_reg       <= write_data;
                            default:            ;
                        endcase
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.step)
            begin
                if (status.div_busy)
                begin
                    div_pre_reg   <= div_pre_reg - DIV_PERIOD_V;
                    div_count_reg <= div_count_reg + 8'd1;
                end
                if (status.tim_busy)
                begin
                    if (chunk_wrap)
                    begin
                        tima_reg    <= tma_reg;
                        steps_reg   <= steps_reg - gap[hct_pkg::STEP_W-1:0];
                        irq_acc_reg <= 1'b1;
                    end
                    else
                    begin
                        tima_reg  <= tima_reg + 8'(steps_reg);
                        steps_reg <= '0;
                    end
                end
            end

            if (cmd.load_out)
            begin
                read_data_reg    <= res_data_reg;
                overflow_irq_reg <= irq_acc_reg;
            end
        end
    end

endmodule
